// ----- rtl/bmwq_pkg.sv -----
package bmwq_pkg;

  localparam int NUM_POOLS      = 3;
  localparam int POOL_ITEMS     = 64;
  localparam int QUEUE_DEPTH    = 16;
  localparam int REQUESTER_BITS = 8;

  localparam int POOL_W   = 2;
  localparam int ITEM_W   = 7;
  localparam int BIT_W    = $clog2(POOL_ITEMS);
  localparam int HEAD_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 7;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HANDED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_REL    = 3'd5;

  typedef logic [POOL_ITEMS-1:0] map_t;

  typedef struct packed {
    logic                      opcode;
    logic [POOL_W-1:0]         pool_select;
    logic [REQUESTER_BITS-1:0] requester;
    logic [ITEM_W-1:0]         item_number;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [ITEM_W-1:0]         granted_item;
    logic [REQUESTER_BITS-1:0] waiter;
  } result_t;

  // Free bitmap with the lowest n items set.
  function automatic map_t init_map(input logic [ITEM_W-1:0] n);
    map_t m;
    if (n >= ITEM_W'(POOL_ITEMS)) begin
      m = '1;
    end else begin
      m = (map_t'(1) << n) - map_t'(1);
    end
    return m;
  endfunction

endpackage

// ----- rtl/bmwq_ffs.sv -----
module bmwq_ffs (
  input  bmwq_pkg::map_t                  map,
  output logic [bmwq_pkg::BIT_W-1:0]      index,
  output logic                            found
);

  // Lowest set bit wins.
  always_comb begin
    index = '0;
    for (int i = bmwq_pkg::POOL_ITEMS - 1; i >= 0; i--) begin
      if (map[i]) begin
        index = bmwq_pkg::BIT_W'(i);
      end
    end
    found = |map;
  end

endmodule

// ----- rtl/bmwq_engine.sv -----
module bmwq_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bmwq_pkg::POOL_W-1:0]        cfg_index,
  input  logic [bmwq_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               step,
  input  bmwq_pkg::item_t                    item,
  output bmwq_pkg::result_t                  result
);

  logic [bmwq_pkg::ITEM_W-1:0]         pool_size  [bmwq_pkg::NUM_POOLS];
  bmwq_pkg::map_t                      free_map   [bmwq_pkg::NUM_POOLS];
  logic [bmwq_pkg::ITEM_W-1:0]         free_count [bmwq_pkg::NUM_POOLS];
  logic [bmwq_pkg::HEAD_W-1:0]         fifo_head  [bmwq_pkg::NUM_POOLS];
  logic [bmwq_pkg::HEAD_W-1:0]         fifo_tail  [bmwq_pkg::NUM_POOLS];
  logic [bmwq_pkg::FILL_W-1:0]         fifo_fill  [bmwq_pkg::NUM_POOLS];
  logic [bmwq_pkg::REQUESTER_BITS-1:0] head_word  [bmwq_pkg::NUM_POOLS];

  logic                          sel_ok;
  logic [bmwq_pkg::POOL_W-1:0]   p;
  bmwq_pkg::map_t                cur_map;
  logic [bmwq_pkg::BIT_W-1:0]    ffs_index;
  logic                          ffs_found;
  logic [bmwq_pkg::BIT_W-1:0]    rel_bit;
  logic                          rel_ok;
  logic                          do_grant;
  logic                          do_queue;
  logic                          do_hand;
  logic                          do_free;
  logic [bmwq_pkg::CFG_W-1:0]    cfg_sat;

  assign sel_ok  = item.pool_select < bmwq_pkg::POOL_W'(bmwq_pkg::NUM_POOLS);
  assign p       = sel_ok ? item.pool_select : '0;
  assign cur_map = free_map[p];
  assign rel_bit = bmwq_pkg::BIT_W'(item.item_number - bmwq_pkg::ITEM_W'(1));
  assign cfg_sat = (cfg_data > bmwq_pkg::CFG_W'(bmwq_pkg::POOL_ITEMS)) ?
                   bmwq_pkg::CFG_W'(bmwq_pkg::POOL_ITEMS) : cfg_data;

  bmwq_ffs u_ffs (
    .map   (cur_map),
    .index (ffs_index),
    .found (ffs_found)
  );

  always_comb begin
    rel_ok   = (item.item_number != '0) && (item.item_number <= pool_size[p]) &&
               !cur_map[rel_bit];
    do_grant = 1'b0;
    do_queue = 1'b0;
    do_hand  = 1'b0;
    do_free  = 1'b0;
    result   = '0;
    if (!sel_ok) begin
      result.status = (item.opcode == bmwq_pkg::OP_RELEASE) ?
                      bmwq_pkg::ST_BAD_REL : bmwq_pkg::ST_QUEUE_FULL;
    end else if (item.opcode == bmwq_pkg::OP_REQUEST) begin
      if (free_count[p] != '0 && ffs_found) begin
        do_grant            = 1'b1;
        result.status       = bmwq_pkg::ST_GRANTED;
        result.granted_item = bmwq_pkg::ITEM_W'(ffs_index) + bmwq_pkg::ITEM_W'(1);
      end else if (fifo_fill[p] < bmwq_pkg::FILL_W'(bmwq_pkg::QUEUE_DEPTH)) begin
        do_queue      = 1'b1;
        result.status = bmwq_pkg::ST_QUEUED;
      end else begin
        result.status = bmwq_pkg::ST_QUEUE_FULL;
      end
    end else begin
      if (!rel_ok) begin
        result.status = bmwq_pkg::ST_BAD_REL;
      end else if (fifo_fill[p] != '0) begin
        do_hand             = 1'b1;
        result.status       = bmwq_pkg::ST_HANDED;
        result.granted_item = item.item_number;
        result.waiter       = head_word[p];
      end else begin
        do_free       = 1'b1;
        result.status = bmwq_pkg::ST_FREED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bmwq_pkg::NUM_POOLS; i++) begin
        pool_size[i]  <= bmwq_pkg::ITEM_W'(bmwq_pkg::POOL_ITEMS);
        free_map[i]   <= '1;
        free_count[i] <= bmwq_pkg::ITEM_W'(bmwq_pkg::POOL_ITEMS);
        fifo_head[i]  <= '0;
        fifo_tail[i]  <= '0;
        fifo_fill[i]  <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index < bmwq_pkg::POOL_W'(bmwq_pkg::NUM_POOLS)) begin
        pool_size[cfg_index]  <= cfg_sat;
        free_map[cfg_index]   <= bmwq_pkg::init_map(cfg_sat);
        free_count[cfg_index] <= cfg_sat;
        fifo_head[cfg_index]  <= '0;
        fifo_tail[cfg_index]  <= '0;
        fifo_fill[cfg_index]  <= '0;
      end
    end else if (step) begin
      if (do_grant) begin
        free_map[p][ffs_index] <= 1'b0;
        free_count[p]          <= free_count[p] - bmwq_pkg::ITEM_W'(1);
      end
      if (do_queue) begin
        fifo_tail[p] <= (fifo_tail[p] == bmwq_pkg::HEAD_W'(bmwq_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : fifo_tail[p] + bmwq_pkg::HEAD_W'(1);
        fifo_fill[p] <= fifo_fill[p] + bmwq_pkg::FILL_W'(1);
      end
      if (do_hand) begin
        fifo_head[p] <= (fifo_head[p] == bmwq_pkg::HEAD_W'(bmwq_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : fifo_head[p] + bmwq_pkg::HEAD_W'(1);
        fifo_fill[p] <= fifo_fill[p] - bmwq_pkg::FILL_W'(1);
      end
      if (do_free) begin
        free_map[p][rel_bit] <= 1'b1;
        if (free_count[p] < pool_size[p]) begin
          free_count[p] <= free_count[p] + bmwq_pkg::ITEM_W'(1);
        end
      end
    end
  end

  // Each pool keeps its waiters in a small register queue of its own. Only
  // pushed entries are ever read, so the storage needs no reset.
  for (genvar g = 0; g < bmwq_pkg::NUM_POOLS; g++) begin : g_queue
    logic [bmwq_pkg::REQUESTER_BITS-1:0] fifo_mem [bmwq_pkg::QUEUE_DEPTH];

    always_ff @(posedge clk) begin
      if (step && do_queue && !cfg_we && p == bmwq_pkg::POOL_W'(g)) begin
        fifo_mem[fifo_tail[g]] <= item.requester;
      end
    end

    assign head_word[g] = fifo_mem[fifo_head[g]];
  end

endmodule

// ----- rtl/bitmap_allocator_with_wait_queue.sv -----
// Three-pool first-fit allocator with a waiter queue per pool.
// Input words arrive on s_tvalid/s_tready: s_tuser carries the opcode (request
// or release) and the pool select, s_tdata the requester and the item number.
// A request takes the lowest free item of the pool, or queues the requester
// when the pool is empty; a release hands the item to the oldest waiter or
// marks it free again. Full queues and bad releases are reported and ignored.
// One result word per input word leaves on m_tvalid/m_tready: m_tuser holds
// the status, m_tdata the granted item and the waiter that received it.
// Each word is captured in an input register, decided by the bitmap search
// and queue update, and lands in an output register.
// Throughput is one word per cycle unless m_tready stalls the output; the 64-bit
// lowest-set-bit search and pointer update are combinational. When m_tready is
// low the output register holds and the input register still takes one more word.
// The user must write pool sizes through cfg_we/cfg_index/cfg_data only while
// idle, which the block does not enforce; a write frees every item of that
// pool and empties its queue. Reset (rst, synchronous) sets all pool sizes to
// 64 with every item free and every queue empty; no clearing pass is needed.
module bitmap_allocator_with_wait_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,  // requester, item_number
  input  logic [2:0]                         s_tuser,  // opcode, pool_select
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [15:0]                        m_tdata,  // granted_item, waiter
  output logic [2:0]                         m_tuser,  // status
  input  logic                               cfg_we,
  input  logic [bmwq_pkg::POOL_W-1:0]        cfg_index,
  input  logic [bmwq_pkg::CFG_W-1:0]         cfg_data
);

  logic              in_valid;
  bmwq_pkg::item_t   in_item;
  logic              out_valid;
  bmwq_pkg::result_t out_res;
  bmwq_pkg::result_t result;
  logic              advance;
  logic              step;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode      <= s_tuser[0];
      in_item.pool_select <= s_tuser[2:1];
      in_item.requester   <= s_tdata[7:0];
      in_item.item_number <= s_tdata[14:8];
    end
  end

  bmwq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (in_item),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {1'b0, out_res.waiter, out_res.granted_item};

endmodule
